[rtl/dssm_pkg.sv]
// Package for the dual stack shared memory block.
// Holds the memory geometry, mode and status codes, and the controller state type.
// No dependencies.
package dssm_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_ONE = 3'd0,
    MODE_PUSH_TWO = 3'd1,
    MODE_POP_ONE  = 3'd2,
    MODE_POP_TWO  = 3'd3,
    MODE_LIST_ONE = 3'd4,
    MODE_LIST_TWO = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

endpackage

[rtl/dssm_ram.sv]
// Shared word store of the dual stack block: one write port, one read port.
// Read data is registered and holds while no read is issued.
// Depends on dssm_pkg.
module dssm_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [dssm_pkg::AW-1:0]   waddr,
  input  logic [dssm_pkg::DW-1:0]   wdata,
  input  logic                      re,
  input  logic [dssm_pkg::AW-1:0]   raddr,
  output logic [dssm_pkg::DW-1:0]   rdata
);
  import dssm_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/dual_stack_shared_memory.sv]
// Two LIFO stacks sharing one word store: stack one grows up, stack two down.
// Depends on dssm_pkg and dssm_ram.
//
// Usage:
//   Input channel in_valid/in_ready carries in_mode and in_value; the result
//   channel out_valid/out_ready carries out_data, out_status and out_last.
//   Push: one result, registered in the accepting cycle.
//   Pop: one store read, its word passing the store read register, then the
//   output register. List: one result per stacked word, one per cycle while
//   the receiver takes them, after an initial read; an empty stack gives one
//   empty-status result. out_last marks the final result of each transaction.
//   Modes 6 and 7 are accepted and give no result.
//   Throughput: one push per cycle while results are taken; a pop or list
//   occupies the block until its final word is loaded into the output
//   register, which is bounded by the single store read port.
//   Reset clears both stack counts and the controller; the store content is
//   left as is and is only read where a push wrote it.
//   When the receiver stalls, the output register holds its result and the
//   block stops taking transactions and issuing reads until it drains.
module dual_stack_shared_memory (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                in_mode,
  input  logic signed [31:0]        in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_data,
  output logic [1:0]                out_status,
  output logic                      out_last
);
  import dssm_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_lo_r, cnt_lo_nxt;
  logic [CW-1:0] cnt_hi_r, cnt_hi_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          down_r, down_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  status_t       out_status_r, out_status_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_free;
  logic          in_acc;
  logic          full;
  logic [CW:0]   used;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [CW-1:0] hi_plus;
  logic [AW-1:0] next_addr;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_acc   = in_valid && in_ready;
  assign used     = {1'b0, cnt_lo_r} + {1'b0, cnt_hi_r};
  assign full     = used >= (CW + 1)'(DEPTH);
  assign hi_plus  = cnt_hi_r + CW'(1);
  assign next_addr = down_r ? addr_r - AW'(1) : addr_r + AW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_POP_ONE:  if (cnt_lo_r != '0) state_nxt = S_BURST;
            MODE_POP_TWO:  if (cnt_hi_r != '0) state_nxt = S_BURST;
            MODE_LIST_ONE: if (cnt_lo_r != '0) state_nxt = S_BURST;
            MODE_LIST_TWO: if (cnt_hi_r != '0) state_nxt = S_BURST;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_BURST: begin
        if (out_free && rem_r == CW'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_lo_nxt     = cnt_lo_r;
    cnt_hi_nxt     = cnt_hi_r;
    rem_nxt        = rem_r;
    addr_nxt       = addr_r;
    down_nxt       = down_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = cnt_lo_r[AW-1:0];
    ram_re         = 1'b0;
    ram_raddr      = addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          out_last_nxt   = 1'b1;
          unique case (in_mode)
            MODE_PUSH_ONE: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = cnt_lo_r[AW-1:0];
                cnt_lo_nxt = cnt_lo_r + CW'(1);
              end
            end
            MODE_PUSH_TWO: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = AW'(CW'(DEPTH) - hi_plus);
                cnt_hi_nxt = hi_plus;
              end
            end
            MODE_POP_ONE: begin
              if (cnt_lo_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(cnt_lo_r - CW'(1));
                cnt_lo_nxt = cnt_lo_r - CW'(1);
                rem_nxt    = CW'(1);
              end
            end
            MODE_POP_TWO: begin
              if (cnt_hi_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(CW'(DEPTH) - cnt_hi_r);
                cnt_hi_nxt = cnt_hi_r - CW'(1);
                rem_nxt    = CW'(1);
              end
            end
            MODE_LIST_ONE: begin
              if (cnt_lo_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                addr_nxt  = '0;
                down_nxt  = 1'b0;
                rem_nxt   = cnt_lo_r;
              end
            end
            MODE_LIST_TWO: begin
              if (cnt_hi_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(DEPTH - 1);
                addr_nxt  = AW'(DEPTH - 1);
                down_nxt  = 1'b1;
                rem_nxt   = cnt_hi_r;
              end
            end
            default: out_valid_nxt = out_valid_r && !out_ready;
          endcase
        end
      end
      S_BURST: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = ram_rdata;
          out_status_nxt = ST_OK;
          out_last_nxt   = (rem_r == CW'(1));
          rem_nxt        = rem_r - CW'(1);
          if (rem_r != CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = next_addr;
            addr_nxt  = next_addr;
          end
        end
      end
      default: out_valid_nxt = out_valid_r && !out_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_lo_r    <= '0;
      cnt_hi_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_lo_r    <= cnt_lo_nxt;
      cnt_hi_r    <= cnt_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    addr_r       <= addr_nxt;
    down_r       <= down_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  dssm_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

[verif/tb_dual_stack_shared_memory.sv]
// Self-checking testbench for dual_stack_shared_memory: push, pop and list traffic
// on both stacks, predicted in place and checked result by result.
// Depends on dssm_pkg and the dual_stack_shared_memory RTL.
`timescale 1ns / 100ps

module tb_dual_stack_shared_memory;
  import dssm_pkg::*;

  localparam logic [2:0]  MODE_SPARE_SIX   = 3'd6;
  localparam logic [2:0]  MODE_SPARE_SEVEN = 3'd7;
  localparam int unsigned HOLD_CYCLES      = 80;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned RANDOM_ITEMS     = 385;

  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } stack_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_mode;
  logic signed [31:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_data;
  logic [1:0]         out_status;
  logic               out_last;

  stack_result_t pending_results[$];
  logic [31:0]   shadow_words [DEPTH];
  int unsigned   low_depth;
  int unsigned   high_depth;
  int unsigned   error_count;
  bit            in_idle_en;
  bit            out_idle_en;
  bit            hold_req;
  int unsigned   stall_left;
  int unsigned   quiet_cycles;

  dual_stack_shared_memory dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned draw_gap(input bit enable);
    int unsigned r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_result(input logic [31:0] d, input status_t s,
                                       input logic l);
    stack_result_t r;
    r.data   = d;
    r.status = s;
    r.last   = l;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_stack_op(input logic [2:0] m, input logic [31:0] v);
    int unsigned k;
    bit          no_room;
    no_room = (low_depth + high_depth) >= DEPTH;
    case (m)
      MODE_PUSH_ONE: begin
        if (no_room) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          shadow_words[low_depth] = v;
          low_depth++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      MODE_PUSH_TWO: begin
        if (no_room) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          high_depth++;
          shadow_words[DEPTH - high_depth] = v;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      MODE_POP_ONE: begin
        if (low_depth == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          low_depth--;
          queue_result(shadow_words[low_depth], ST_OK, 1'b1);
        end
      end
      MODE_POP_TWO: begin
        if (high_depth == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          queue_result(shadow_words[DEPTH - high_depth], ST_OK, 1'b1);
          high_depth--;
        end
      end
      MODE_LIST_ONE: begin
        if (low_depth == 0) queue_result('0, ST_EMPTY, 1'b1);
        for (k = 0; k < low_depth; k++)
          queue_result(shadow_words[k], ST_OK, k + 1 == low_depth);
      end
      MODE_LIST_TWO: begin
        if (high_depth == 0) queue_result('0, ST_EMPTY, 1'b1);
        for (k = 0; k < high_depth; k++)
          queue_result(shadow_words[DEPTH - 1 - k], ST_OK, k + 1 == high_depth);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(input logic [2:0] m, input logic [31:0] v);
    int unsigned gap;
    gap = draw_gap(in_idle_en);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_mode  <= 3'($urandom);
      in_value <= $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_stack_op(m, v);
  endtask

  task automatic send_random_item(input int unsigned push_pct, output bit counted);
    int unsigned r;
    logic [2:0]  m;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 3) begin
      m = $urandom_range(0, 1) ? MODE_SPARE_SIX : MODE_SPARE_SEVEN;
      counted = 1'b0;
    end else if (r < 3 + push_pct) begin
      m = $urandom_range(0, 1) ? MODE_PUSH_ONE : MODE_PUSH_TWO;
    end else if (r < 15 + push_pct) begin
      m = $urandom_range(0, 1) ? MODE_LIST_ONE : MODE_LIST_TWO;
    end else begin
      m = $urandom_range(0, 1) ? MODE_POP_ONE : MODE_POP_TWO;
    end
    send_item(m, draw_word());
  endtask

  task automatic test_empty_stacks();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_item(MODE_POP_ONE, 32'h1234_5678);
    send_item(MODE_POP_TWO, 32'h8765_4321);
    send_item(MODE_SPARE_SEVEN, 32'hDEAD_BEEF);
    send_item(MODE_LIST_ONE, '0);
    send_item(MODE_LIST_TWO, '0);
  endtask

  task automatic test_fill_to_full();
    logic [31:0] patterns [8];
    int unsigned k;
    patterns = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFE};
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    for (k = 0; k < DEPTH; k++)
      send_item(k % 8 < 5 ? MODE_PUSH_ONE : MODE_PUSH_TWO, patterns[k % 8]);
    send_item(MODE_PUSH_ONE, 32'h1357_9BDF);
    send_item(MODE_PUSH_TWO, 32'h2468_ACE0);
    send_item(MODE_LIST_ONE, '0);
    send_item(MODE_LIST_TWO, '0);
  endtask

  task automatic test_output_stall();
    int unsigned k;
    bit          counted;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    hold_req    = 1'b1;
    for (k = 0; k < 20; k++) send_random_item(45, counted);
  endtask

  task automatic test_random_traffic(input int unsigned item_total);
    int unsigned sent;
    int unsigned round;
    int unsigned push_pct;
    bit          counted;
    sent     = 0;
    round    = 0;
    push_pct = 25;
    while (sent < item_total) begin
      if (round % 40 == 0) begin
        push_pct    = (push_pct > 45) ? 25 : 70;
        in_idle_en  = ((round / 40) % 4) != 1;
        out_idle_en = ((round / 40) % 4) != 2;
      end
      send_random_item(push_pct, counted);
      if (counted) sent++;
      round++;
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_mode     = MODE_PUSH_ONE;
    in_value    = '0;
    low_depth   = 0;
    high_depth  = 0;
    error_count = 0;
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    hold_req    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_stacks();
    test_fill_to_full();
    test_output_stall();
    test_random_traffic(RANDOM_ITEMS);

    @(negedge clk);
    in_valid    <= 1'b0;
    out_idle_en  = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = draw_gap(out_idle_en);
      end
    end
  end

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction data=%h status=%0d last=%b",
                 $time, out_data, out_status, out_last);
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want.data) begin
          error_count++;
          $display("%0t: out_data expected %h, actual %h", $time, want.data, out_data);
        end
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: out_status expected %0d, actual %0d",
                   $time, want.status, out_status);
        end
        if (out_last !== want.last) begin
          error_count++;
          $display("%0t: out_last expected %b, actual %b", $time, want.last, out_last);
        end
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: watchdog expired with %0d results outstanding",
             $time, pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
